/* rtl/hts_pkg.sv */
package hts_pkg;

    localparam int DEF_MAX_WIDTH = 1024;

    localparam int PIX_W      = 8;
    localparam int IMG_W_W    = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    localparam logic [PIX_W-1:0]   RST_LOW_THR   = 8'd50;
    localparam logic [PIX_W-1:0]   RST_HIGH_THR  = 8'd100;
    localparam logic [IMG_W_W-1:0] RST_IMG_WIDTH = 11'd640;

    localparam logic [PIX_W-1:0] VAL_BG     = 8'd0;
    localparam logic [PIX_W-1:0] VAL_WEAK   = 8'd1;
    localparam logic [PIX_W-1:0] VAL_STRONG = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_THR   = 2'd0,
        REG_HIGH_THR  = 2'd1,
        REG_IMG_WIDTH = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CLS_BG     = 2'd0,
        CLS_WEAK   = 2'd1,
        CLS_STRONG = 2'd2
    } pix_class_t;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } item_kind_t;

    // per-item decisions handed from the ring control to the datapath
    typedef struct packed {
        logic emit;
        logic pend_we;
        logic right_ok;
        logic right_new;
        logic left_ok;
        logic frame_end;
    } issue_t;

    function automatic pix_class_t classify(input logic [PIX_W-1:0] x,
                                            input logic [PIX_W-1:0] lo,
                                            input logic [PIX_W-1:0] hi);
        pix_class_t c;
        if (x >= hi) begin
            c = CLS_STRONG;
        end else if (x <= lo) begin
            c = CLS_BG;
        end else begin
            c = CLS_WEAK;
        end
        return c;
    endfunction

    function automatic logic [PIX_W-1:0] class_value(input pix_class_t c);
        logic [PIX_W-1:0] v;
        case (c)
            CLS_STRONG: v = VAL_STRONG;
            CLS_WEAK:   v = VAL_WEAK;
            default:    v = VAL_BG;
        endcase
        return v;
    endfunction

endpackage

/* rtl/hysteresis_threshold_stream_core.sv */
// Streaming double-threshold hysteresis over a raster-order pixel stream.
//
// Input words: s_tdata carries the 8-bit intensity, s_tuser the item kind
// (0 pixel, 1 flush). Each pixel is classed strong, weak or background from
// the two thresholds; a weak pixel is promoted when the resolved pixel one
// row-minus-one back and the pixel one row-minus-one ahead are both strong.
// Output words: m_tdata is 0, 1 or 255; m_tlast marks the last pixel of the
// frame. Results trail the input by image_width-1 pixels; send flush words at
// frame end, one per pending pixel, to drain them.
// A word that produces a result passes through the resolve stage and then the
// output register before it shows on m_tvalid. Throughput is one word per cycle
// while m_tready does not stall, with one registered line-memory read step per word.
// Configuration: cfg_we/cfg_index/cfg_wdata write low threshold (0), high
// threshold (1) and image width (2); write only while the block is idle.
// Reset clears the queue and frame counters and loads thresholds 50/100 and
// width 640; line memories are not cleared, no clearing pass is needed.
// When m_tready is low the resolve stage and the output register hold their
// words and s_tready drops once both are full.
module hysteresis_threshold_stream_core #(
    parameter int MAX_WIDTH = hts_pkg::DEF_MAX_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hts_pkg::PIX_W-1:0]       s_tdata,   // [7:0] intensity
    input  logic [0:0]                      s_tuser,   // [0] kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hts_pkg::PIX_W-1:0]       m_tdata,   // [7:0] pixel_value
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [hts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import hts_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic             accept;
    item_kind_t       kind;
    logic [PIX_W-1:0] low_thr;
    logic [PIX_W-1:0] high_thr;
    logic [AW-1:0]    offset;
    issue_t           issue;
    logic [AW-1:0]    pend_wr_addr;
    logic [AW-1:0]    head_addr;
    logic [AW-1:0]    right_addr;
    logic [AW-1:0]    left_addr;

    assign accept = s_tvalid && s_tready;
    assign kind   = item_kind_t'(s_tuser[0]);

    hts_cfg_regs #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .low_thr   (low_thr),
        .high_thr  (high_thr),
        .offset    (offset)
    );

    hts_ring_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .kind         (kind),
        .offset       (offset),
        .issue        (issue),
        .pend_wr_addr (pend_wr_addr),
        .head_addr    (head_addr),
        .right_addr   (right_addr),
        .left_addr    (left_addr)
    );

    hts_resolve #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_resolve (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .in_ready     (s_tready),
        .intensity    (s_tdata),
        .low_thr      (low_thr),
        .high_thr     (high_thr),
        .issue        (issue),
        .pend_wr_addr (pend_wr_addr),
        .head_addr    (head_addr),
        .right_addr   (right_addr),
        .left_addr    (left_addr),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

/* rtl/hts_cfg_regs.sv */
module hts_cfg_regs #(
    parameter int MAX_WIDTH = hts_pkg::DEF_MAX_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [hts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output logic [hts_pkg::PIX_W-1:0]           low_thr,
    output logic [hts_pkg::PIX_W-1:0]           high_thr,
    output logic [$clog2(MAX_WIDTH)-1:0]        offset
);
    import hts_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int EW = ((IMG_W_W > CW) ? IMG_W_W : CW) + 1;

    logic [PIX_W-1:0] low_reg, low_next;
    logic [PIX_W-1:0] high_reg, high_next;
    logic [AW-1:0]    offset_reg, offset_next;

    // clamp the width into 2..MAX_WIDTH and keep only the neighbor offset
    function automatic logic [AW-1:0] width_to_offset(input logic [IMG_W_W-1:0] w);
        logic [EW-1:0] wide;
        logic [EW-1:0] clamped;
        wide = EW'(w);
        if (wide < EW'(2)) begin
            clamped = EW'(2);
        end else if (wide > EW'(MAX_WIDTH)) begin
            clamped = EW'(MAX_WIDTH);
        end else begin
            clamped = wide;
        end
        return AW'(clamped - EW'(1));
    endfunction

    always_comb begin
        low_next    = low_reg;
        high_next   = high_reg;
        offset_next = offset_reg;
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LOW_THR:   low_next    = cfg_wdata[PIX_W-1:0];
                REG_HIGH_THR:  high_next   = cfg_wdata[PIX_W-1:0];
                REG_IMG_WIDTH: offset_next = width_to_offset(cfg_wdata[IMG_W_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg    <= RST_LOW_THR;
            high_reg   <= RST_HIGH_THR;
            offset_reg <= width_to_offset(RST_IMG_WIDTH);
        end else begin
            low_reg    <= low_next;
            high_reg   <= high_next;
            offset_reg <= offset_next;
        end
    end

    assign low_thr  = low_reg;
    assign high_thr = high_reg;
    assign offset   = offset_reg;

endmodule

/* rtl/hts_ring_ctrl.sv */
module hts_ring_ctrl #(
    parameter int MAX_WIDTH = hts_pkg::DEF_MAX_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  hts_pkg::item_kind_t             kind,
    input  logic [$clog2(MAX_WIDTH)-1:0]    offset,
    output hts_pkg::issue_t                 issue,
    output logic [$clog2(MAX_WIDTH)-1:0]    pend_wr_addr,
    output logic [$clog2(MAX_WIDTH)-1:0]    head_addr,
    output logic [$clog2(MAX_WIDTH)-1:0]    right_addr,
    output logic [$clog2(MAX_WIDTH)-1:0]    left_addr
);
    import hts_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int SW = AW + 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);

    localparam logic [SW-1:0] RING_SIZE = SW'(MAX_WIDTH);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] count_reg, count_next;
    logic [CW-1:0] emitted_reg, emitted_next;
    logic [CW-1:0] emitted_inc;
    logic [SW-1:0] back_off;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [SW-1:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= RING_SIZE) begin
            sum = sum - RING_SIZE;
        end
        return sum[AW-1:0];
    endfunction

    assign back_off     = RING_SIZE - {1'b0, offset};
    assign pend_wr_addr = ring_add(head_reg, count_reg);
    assign head_addr    = head_reg;
    assign right_addr   = ring_add(head_reg, offset);
    assign left_addr    = ring_add(head_reg, back_off[AW-1:0]);

    always_comb begin
        issue        = '0;
        head_next    = head_reg;
        count_next   = count_reg;
        emitted_next = emitted_reg;
        emitted_inc  = (emitted_reg == CW'(MAX_WIDTH)) ? emitted_reg : emitted_reg + CW'(1);

        if (kind == KIND_PIXEL) begin
            issue.pend_we   = 1'b1;
            issue.emit      = count_reg >= offset;
            issue.right_ok  = 1'b1;
            // right neighbor is the pixel being written this cycle
            issue.right_new = count_reg == offset;
        end else begin
            issue.emit      = count_reg != '0;
            issue.right_ok  = offset < count_reg;
            issue.frame_end = count_reg == AW'(1);
        end
        issue.left_ok = emitted_reg >= CW'(offset);

        if (accept) begin
            if (issue.emit) begin
                head_next    = ring_add(head_reg, AW'(1));
                emitted_next = issue.frame_end ? '0 : emitted_inc;
                if (kind == KIND_FLUSH) begin
                    count_next = count_reg - AW'(1);
                end
            end else if (kind == KIND_PIXEL) begin
                count_next = count_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            emitted_reg <= '0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            emitted_reg <= emitted_next;
        end
    end

    a_frame_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && issue.frame_end |=> count_reg == '0 && emitted_reg == '0)
        else $error("frame end did not empty the queue");

    a_pixel_queues: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && kind == KIND_PIXEL && !issue.emit |=> count_reg == $past(count_reg) + AW'(1))
        else $error("non-emitting pixel did not grow the queue");

    a_empty_flush_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && kind == KIND_FLUSH && count_reg == '0 |=>
        $stable(head_reg) && $stable(count_reg) && $stable(emitted_reg))
        else $error("flush on empty queue changed state");

endmodule

/* rtl/hts_resolve.sv */
module hts_resolve #(
    parameter int MAX_WIDTH = hts_pkg::DEF_MAX_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    output logic                            in_ready,
    input  logic [hts_pkg::PIX_W-1:0]       intensity,
    input  logic [hts_pkg::PIX_W-1:0]       low_thr,
    input  logic [hts_pkg::PIX_W-1:0]       high_thr,
    input  hts_pkg::issue_t                 issue,
    input  logic [$clog2(MAX_WIDTH)-1:0]    pend_wr_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]    head_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]    right_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]    left_addr,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hts_pkg::PIX_W-1:0]       m_tdata,
    output logic                            m_tlast
);
    import hts_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    // line memories: queued classes and strong flags of emitted pixels
    pix_class_t pend_mem [MAX_WIDTH];
    logic       fin_mem  [MAX_WIDTH];

    pix_class_t cls_in;

    logic          a_valid_reg;
    issue_t        a_issue_reg;
    logic [AW-1:0] a_head_reg;
    logic          a_left_fwd_reg;
    logic          a_new_strong_reg;
    pix_class_t    pend_head_reg;
    pix_class_t    pend_right_reg;
    logic          fin_left_reg;

    logic             m_valid_reg;
    logic [PIX_W-1:0] m_data_reg;
    logic             m_last_reg;
    logic             last_strong_reg;

    logic       out_free;
    logic       advance;
    logic       left_strong;
    logic       right_strong;
    pix_class_t final_cls;
    logic       final_strong;

    assign cls_in   = classify(intensity, low_thr, high_thr);
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = a_valid_reg && out_free;
    assign in_ready = !a_valid_reg || out_free;

    always_comb begin
        left_strong  = a_issue_reg.left_ok &&
                       (a_left_fwd_reg ? last_strong_reg : fin_left_reg);
        right_strong = a_issue_reg.right_ok &&
                       (a_issue_reg.right_new ? a_new_strong_reg
                                              : (pend_right_reg == CLS_STRONG));
        final_cls    = pend_head_reg;
        if (pend_head_reg == CLS_WEAK && left_strong && right_strong) begin
            final_cls = CLS_STRONG;
        end
        final_strong = final_cls == CLS_STRONG;
    end

    always_ff @(posedge aclk) begin
        if (accept && issue.pend_we) begin
            pend_mem[pend_wr_addr] <= cls_in;
        end
        if (accept) begin
            pend_head_reg  <= pend_mem[head_addr];
            pend_right_reg <= pend_mem[right_addr];
            fin_left_reg   <= fin_mem[left_addr];
        end
        if (advance) begin
            fin_mem[a_head_reg] <= final_strong;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_issue_reg      <= issue;
            a_head_reg       <= head_addr;
            a_new_strong_reg <= cls_in == CLS_STRONG;
            // left neighbor is being written by the word leaving this stage
            a_left_fwd_reg   <= a_valid_reg && (left_addr == a_head_reg);
        end
        if (advance) begin
            m_data_reg      <= class_value(final_cls);
            m_last_reg      <= a_issue_reg.frame_end;
            last_strong_reg <= final_strong;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                a_valid_reg <= issue.emit;
            end else if (advance) begin
                a_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_value_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg == VAL_BG || m_data_reg == VAL_WEAK ||
                         m_data_reg == VAL_STRONG))
        else $error("illegal pixel value on output");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !out_free |=> a_valid_reg && $stable(a_head_reg))
        else $error("resolve stage lost its word under stall");

    a_stage_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && a_valid_reg |=> m_valid_reg)
        else $error("resolve stage overwritten before draining");

endmodule
